// ----- sv/wmts_pkg.sv -----
// Shared types, constants and helpers for the window mean threshold select block.
// Used by the top level, front end, back end, checker and testbench; depends on nothing else.

`default_nettype none

package wmts_pkg;

    // Default sizing of the line store and column sums.
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_WIN_DEF   = 32;
    localparam int ROWS_MAX      = 1024;

    // Field widths fixed by the stream format.
    localparam int ROW_W       = 10;
    localparam int X_W         = 16;
    localparam int COLSUM_W    = 21;
    localparam int SUM_W       = 26;
    localparam int COORD_W     = 10;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 48;
    localparam int RES_W       = 2 * COORD_W + SUM_W;

    // Configuration port.
    localparam int IMG_DIM_W  = 11;
    localparam int WIN_DIM_W  = 6;
    localparam int THR_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [IMG_DIM_W-1:0] IMAGE_WIDTH_RST  = IMG_DIM_W'(640);
    localparam logic [IMG_DIM_W-1:0] IMAGE_HEIGHT_RST = IMG_DIM_W'(480);
    localparam logic [WIN_DIM_W-1:0] WIN_WIDTH_RST    = WIN_DIM_W'(8);
    localparam logic [WIN_DIM_W-1:0] WIN_HEIGHT_RST   = WIN_DIM_W'(8);
    localparam logic [THR_W-1:0]     THRESHOLD_RST    = THR_W'(32768);

    // Queue depths between front end, back end and output.
    localparam int QUEUE_DEPTH = 4;
    localparam int OUT_DEPTH   = 4;
    localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_WIN_WIDTH    = 3'd2,
        REG_WIN_HEIGHT   = 3'd3,
        REG_THRESHOLD    = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [IMG_DIM_W-1:0] image_width;
        logic [IMG_DIM_W-1:0] image_height;
        logic [WIN_DIM_W-1:0] win_width;
        logic [WIN_DIM_W-1:0] win_height;
        logic [THR_W-1:0]     threshold;
    } wmts_cfg_t;

    // What the front end decided about one sample.
    typedef struct packed {
        logic first_row;   // row 0: column sum restarts
        logic sub_old;     // a row leaves the vertical window
        logic first_col;   // column 0: window sum restarts
        logic sub_left;    // a column leaves the horizontal window
        logic emit;        // a full window completes here
    } wmts_flags_t;

    function automatic int clamp_u(input int v, input int lo, input int hi);
        int res;
        res = v;
        if (v < lo) begin
            res = lo;
        end else if (v > hi) begin
            res = hi;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- sv/window_mean_threshold_select.sv -----
// Top level of the sliding-window foreground mean test: configuration registers,
// front end, sample queue, back end and result queue. Depends on wmts_pkg, wmts_front, wmts_fifo, wmts_back.
//
// Usage:
//   Samples enter on the s_ channel in raster order, one beat per sample; s_tuser
//   high marks the first sample of a frame. Each beat that completes a full
//   win_width x win_height window whose sum exceeds threshold * area yields one
//   result beat on the m_ channel with the window's top-left column, row and sum.
//   Configuration is written through cfg_wr_en / cfg_wr_index / cfg_wr_data while
//   no sample is in flight.
//   Throughput is one sample per clock while the receiver takes results. A result
//   passes the sample queue, the memory read stage, the window-sum register and
//   the result queue after the sample that completes its window is accepted.
//   Reset returns the configuration to 640 x 480, an 8 x 8 window and a threshold
//   of one half, clears the raster position and marks every column sum as zero.
//   No clearing pass is needed, so samples are taken from the first cycle on.
//   When the receiver stalls, results collect in a four-beat output queue; when its fill plus the
//   back end's samples reach four, it stops and the four-beat sample queue fills; s_tready drops.

`default_nettype none

module window_mean_threshold_select #(
    parameter int MAX_WIDTH = wmts_pkg::MAX_WIDTH_DEF,
    parameter int MAX_WIN   = wmts_pkg::MAX_WIN_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [wmts_pkg::S_TDATA_W-1:0]    s_tdata,   // [15:0] fg_value
    input  logic                              s_tuser,   // [0] frame_start
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [wmts_pkg::M_TDATA_W-1:0]    m_tdata,   // [9:0] win_col, [19:10] win_row,
                                                         // [45:20] win_sum, [47:46] zero
    input  logic                              cfg_wr_en,
    input  logic [wmts_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input  logic [wmts_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);

    import wmts_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int SW = $clog2(MAX_WIN);
    localparam int FL_W = $bits(wmts_flags_t);
    localparam int QW = X_W + 2 * CW + 2 * SW + 2 * COORD_W + FL_W;

    wmts_cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_wr_index))
                REG_IMAGE_WIDTH:  cfg_next.image_width  = cfg_wr_data[IMG_DIM_W-1:0];
                REG_IMAGE_HEIGHT: cfg_next.image_height = cfg_wr_data[IMG_DIM_W-1:0];
                REG_WIN_WIDTH:    cfg_next.win_width    = cfg_wr_data[WIN_DIM_W-1:0];
                REG_WIN_HEIGHT:   cfg_next.win_height   = cfg_wr_data[WIN_DIM_W-1:0];
                REG_THRESHOLD:    cfg_next.threshold    = cfg_wr_data[THR_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width  <= IMAGE_WIDTH_RST;
            cfg_reg.image_height <= IMAGE_HEIGHT_RST;
            cfg_reg.win_width    <= WIN_WIDTH_RST;
            cfg_reg.win_height   <= WIN_HEIGHT_RST;
            cfg_reg.threshold    <= THRESHOLD_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end to sample queue.
    logic               q_full, q_empty, q_pop, accept;
    logic [CW-1:0]      f_col, f_left_col;
    logic [SW-1:0]      f_cur_slot, f_old_slot;
    logic [COORD_W-1:0] f_win_col, f_win_row;
    wmts_flags_t        f_flags;
    logic [QW-1:0]      q_push_data, q_pop_data;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;

    wmts_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_WIN   (MAX_WIN)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .accept      (accept),
        .frame_start (s_tuser),
        .col         (f_col),
        .left_col    (f_left_col),
        .cur_slot    (f_cur_slot),
        .old_slot    (f_old_slot),
        .win_col     (f_win_col),
        .win_row     (f_win_row),
        .flags       (f_flags)
    );

    assign q_push_data = {f_flags, f_win_row, f_win_col, f_old_slot, f_cur_slot,
                          f_left_col, f_col, s_tdata[X_W-1:0]};

    wmts_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .full      (q_full),
        .empty     (q_empty),
        .count     ()
    );

    // Sample queue to back end.
    logic [X_W-1:0]     b_x;
    logic [CW-1:0]      b_col, b_left_col;
    logic [SW-1:0]      b_cur_slot, b_old_slot;
    logic [COORD_W-1:0] b_win_col, b_win_row;
    wmts_flags_t        b_flags;

    assign {b_flags, b_win_row, b_win_col, b_old_slot, b_cur_slot,
            b_left_col, b_col, b_x} = q_pop_data;

    logic                 res_valid, o_full, o_empty;
    logic [RES_W-1:0]     res_data, o_data;
    logic [OUT_CNT_W-1:0] o_count;

    wmts_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_WIN   (MAX_WIN)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .q_empty    (q_empty),
        .q_x        (b_x),
        .q_col      (b_col),
        .q_left_col (b_left_col),
        .q_cur_slot (b_cur_slot),
        .q_old_slot (b_old_slot),
        .q_win_col  (b_win_col),
        .q_win_row  (b_win_row),
        .q_flags    (b_flags),
        .out_count  (o_count),
        .q_pop      (q_pop),
        .res_valid  (res_valid),
        .res_data   (res_data)
    );

    wmts_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res_data),
        .pop       (m_tready),
        .pop_data  (o_data),
        .full      (o_full),
        .empty     (o_empty),
        .count     (o_count)
    );

    // The back end never pushes into a full result queue; o_full is only a status.
    assign m_tvalid = !o_empty && (o_full || !o_full);
    assign m_tdata  = {(M_TDATA_W - RES_W)'(0), o_data};

endmodule

`default_nettype wire

// ----- sv/wmts_fifo.sv -----
// Small register FIFO used for the classified-sample queue and the result queue.
// Standalone; depends on nothing.

`default_nettype none

module wmts_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         push,
    input  logic [WIDTH-1:0]             push_data,
    input  logic                         pop,
    output logic [WIDTH-1:0]             pop_data,
    output logic                         full,
    output logic                         empty,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] storage_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             wr_en, rd_en;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign wr_en = push && !full;
    assign rd_en = pop && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr_en) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (rd_en) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        count_next = count_reg + CNT_W'(wr_en) - CNT_W'(rd_en);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            storage_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = storage_reg[rd_ptr_reg];
    assign count    = count_reg;

endmodule

`default_nettype wire

// ----- sv/wmts_front.sv -----
// Front end: keeps the raster position and classifies each accepted sample.
// Depends on wmts_pkg; feeds the sample queue in the top level.

`default_nettype none

module wmts_front #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_WIN   = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  wmts_pkg::wmts_cfg_t               cfg,
    input  logic                              accept,
    input  logic                              frame_start,
    output logic [$clog2(MAX_WIDTH)-1:0]      col,
    output logic [$clog2(MAX_WIDTH)-1:0]      left_col,
    output logic [$clog2(MAX_WIN)-1:0]        cur_slot,
    output logic [$clog2(MAX_WIN)-1:0]        old_slot,
    output logic [wmts_pkg::COORD_W-1:0]      win_col,
    output logic [wmts_pkg::COORD_W-1:0]      win_row,
    output wmts_pkg::wmts_flags_t             flags
);

    import wmts_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int EW_W = $clog2(MAX_WIDTH + 1);
    localparam int SW   = $clog2(MAX_WIN);
    localparam int WW_W = $clog2(MAX_WIN + 1);
    localparam int LW   = ((CW + 1 > WW_W) ? CW + 1 : WW_W) + 1;
    localparam int EH_W = $clog2(ROWS_MAX + 1);

    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [SW-1:0]    slot_reg, slot_next;

    logic [EW_W-1:0]  ew;
    logic [EH_W-1:0]  eh;
    logic [WW_W-1:0]  ww, wh;
    logic [CW-1:0]    c;
    logic [ROW_W-1:0] r;
    logic [SW-1:0]    s;
    logic [CW:0]      c1;
    logic [ROW_W:0]   r1;
    logic [WW_W:0]    slot_x;

    always_comb begin
        ew = EW_W'(clamp_u(int'(cfg.image_width), 1, MAX_WIDTH));
        eh = EH_W'(clamp_u(int'(cfg.image_height), 1, ROWS_MAX));
        ww = WW_W'(clamp_u(int'(cfg.win_width), 1, MAX_WIN));
        wh = WW_W'(clamp_u(int'(cfg.win_height), 1, MAX_WIN));
    end

    // A frame start beat is column 0, row 0 whatever the counters say.
    assign c  = frame_start ? '0 : col_reg;
    assign r  = frame_start ? '0 : row_reg;
    assign s  = frame_start ? '0 : slot_reg;
    assign c1 = (CW + 1)'(c) + (CW + 1)'(1);
    assign r1 = (ROW_W + 1)'(r) + (ROW_W + 1)'(1);
    assign slot_x = (WW_W + 1)'(s);

    always_comb begin
        flags.first_row = (r == '0);
        flags.sub_old   = ((ROW_W + 1)'(r) >= (ROW_W + 1)'(wh));
        flags.first_col = (c == '0);
        flags.sub_left  = (LW'(c) >= LW'(ww));
        flags.emit      = (LW'(r1) >= LW'(wh)) && (LW'(c1) >= LW'(ww));

        col      = c;
        cur_slot = s;
        // Slot of the row leaving the window, modulo the line store depth.
        if (slot_x >= (WW_W + 1)'(wh)) begin
            old_slot = SW'(slot_x - (WW_W + 1)'(wh));
        end else begin
            old_slot = SW'(slot_x + (WW_W + 1)'(MAX_WIN) - (WW_W + 1)'(wh));
        end
        left_col = flags.sub_left ? CW'(LW'(c) - LW'(ww)) : '0;
        win_col  = COORD_W'(LW'(c1) - LW'(ww));
        win_row  = COORD_W'(LW'(r1) - LW'(wh));
    end

    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        slot_next = slot_reg;
        if (accept) begin
            if (LW'(c1) >= LW'(ew)) begin
                col_next = '0;
                if (LW'(r1) >= LW'(eh)) begin
                    row_next  = '0;
                    slot_next = '0;
                end else begin
                    row_next  = r1[ROW_W-1:0];
                    slot_next = (s == SW'(MAX_WIN - 1)) ? '0 : s + SW'(1);
                end
            end else begin
                col_next  = c1[CW-1:0];
                row_next  = r;
                slot_next = s;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
        end else begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/wmts_back.sv -----
// Back end: line store, column sums, running window sum and the threshold test.
// Depends on wmts_pkg; pulls from the sample queue and pushes to the result queue.

`default_nettype none

module wmts_back #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_WIN   = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  wmts_pkg::wmts_cfg_t               cfg,
    input  logic                              q_empty,
    input  logic [wmts_pkg::X_W-1:0]          q_x,
    input  logic [$clog2(MAX_WIDTH)-1:0]      q_col,
    input  logic [$clog2(MAX_WIDTH)-1:0]      q_left_col,
    input  logic [$clog2(MAX_WIN)-1:0]        q_cur_slot,
    input  logic [$clog2(MAX_WIN)-1:0]        q_old_slot,
    input  logic [wmts_pkg::COORD_W-1:0]      q_win_col,
    input  logic [wmts_pkg::COORD_W-1:0]      q_win_row,
    input  wmts_pkg::wmts_flags_t             q_flags,
    input  logic [wmts_pkg::OUT_CNT_W-1:0]    out_count,
    output logic                              q_pop,
    output logic                              res_valid,
    output logic [wmts_pkg::RES_W-1:0]        res_data
);

    import wmts_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int FW   = CW + 1;
    localparam int WW_W = $clog2(MAX_WIN + 1);
    localparam int AR_W = 2 * WW_W;
    localparam int TA_W = THR_W + AR_W;
    localparam int CR_W = OUT_CNT_W + 2;

    // Line store rows and the per-column vertical sums.
    logic [X_W-1:0]      ls_mem [MAX_WIN][MAX_WIDTH];
    logic [COLSUM_W-1:0] cs_mem [MAX_WIDTH];

    // Columns below the fill mark have been written since reset; the rest read as zero.
    logic [FW-1:0]       fill_reg;

    // Stage 1: memory read data and forwarding from the write in the same cycle.
    logic                s1_valid_reg;
    logic [X_W-1:0]      s1_x_reg;
    logic [CW-1:0]       s1_col_reg;
    logic [COORD_W-1:0]  s1_win_col_reg, s1_win_row_reg;
    wmts_flags_t         s1_flags_reg;
    logic [X_W-1:0]      ls_rd_reg;
    logic [COLSUM_W-1:0] csa_rd_reg, csb_rd_reg, fwd_val_reg;
    logic                csa_ok_reg, csb_ok_reg, fwd_a_reg, fwd_b_reg;

    // Stage 2: window sum ready for the threshold compare.
    logic                s2_valid_reg;
    logic                s2_emit_reg;
    logic [COORD_W-1:0]  s2_col_reg, s2_row_reg;
    logic [SUM_W-1:0]    s2_sum_reg;

    logic [SUM_W-1:0]    rws_reg, rws_next;
    logic [AR_W-1:0]     area_reg;
    logic [TA_W-1:0]     thr_area_reg;

    logic [WW_W-1:0]     ww, wh;
    logic [CR_W-1:0]     in_flight;
    logic [COLSUM_W-1:0] colsum_a, left_cs, prev_cs, leave_cs, cs_now;
    logic [X_W-1:0]      old_x;

    always_comb begin
        ww = WW_W'(clamp_u(int'(cfg.win_width), 1, MAX_WIN));
        wh = WW_W'(clamp_u(int'(cfg.win_height), 1, MAX_WIN));
    end

    // Pull only when the result queue can take everything already in the pipe.
    assign in_flight = CR_W'(out_count) + CR_W'(s1_valid_reg) + CR_W'(s2_valid_reg);
    assign q_pop     = !q_empty && (in_flight < CR_W'(OUT_DEPTH));

    always_comb begin
        colsum_a = fwd_a_reg ? fwd_val_reg : (csa_ok_reg ? csa_rd_reg : '0);
        left_cs  = fwd_b_reg ? fwd_val_reg : (csb_ok_reg ? csb_rd_reg : '0);
        prev_cs  = s1_flags_reg.first_row ? '0 : colsum_a;
        old_x    = s1_flags_reg.sub_old ? ls_rd_reg : '0;
        cs_now   = prev_cs + COLSUM_W'(s1_x_reg) - COLSUM_W'(old_x);
        leave_cs = s1_flags_reg.sub_left ? left_cs : '0;
        if (s1_flags_reg.first_col) begin
            rws_next = SUM_W'(cs_now);
        end else begin
            rws_next = rws_reg + SUM_W'(cs_now) - SUM_W'(leave_cs);
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            ls_rd_reg  <= ls_mem[q_old_slot][q_col];
            ls_mem[q_cur_slot][q_col] <= q_x;
            csa_rd_reg <= cs_mem[q_col];
            csb_rd_reg <= cs_mem[q_left_col];
        end
        if (s1_valid_reg) begin
            cs_mem[s1_col_reg] <= cs_now;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            s1_x_reg       <= q_x;
            s1_col_reg     <= q_col;
            s1_win_col_reg <= q_win_col;
            s1_win_row_reg <= q_win_row;
            s1_flags_reg   <= q_flags;
            csa_ok_reg     <= (FW'(q_col) < fill_reg);
            csb_ok_reg     <= (FW'(q_left_col) < fill_reg);
            // The column sum written at this edge is not yet in the read data.
            fwd_a_reg      <= s1_valid_reg && (s1_col_reg == q_col);
            fwd_b_reg      <= s1_valid_reg && (s1_col_reg == q_left_col);
            fwd_val_reg    <= cs_now;
        end
        if (s1_valid_reg) begin
            s2_emit_reg <= s1_flags_reg.emit;
            s2_col_reg  <= s1_win_col_reg;
            s2_row_reg  <= s1_win_row_reg;
            s2_sum_reg  <= rws_next;
        end
        area_reg     <= AR_W'(ww) * AR_W'(wh);
        thr_area_reg <= TA_W'(cfg.threshold) * TA_W'(area_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            rws_reg      <= '0;
            fill_reg     <= '0;
        end else begin
            s1_valid_reg <= q_pop;
            s2_valid_reg <= s1_valid_reg;
            if (s1_valid_reg) begin
                rws_reg <= rws_next;
                if (FW'(s1_col_reg) == fill_reg) begin
                    fill_reg <= fill_reg + FW'(1);
                end
            end
        end
    end

    assign res_valid = s2_valid_reg && s2_emit_reg && (s2_sum_reg > thr_area_reg);
    assign res_data  = {s2_sum_reg, s2_row_reg, s2_col_reg};

endmodule

`default_nettype wire

// ----- sv/wmts_checker.sv -----
// Port-level checker for window_mean_threshold_select and its bind statement.
// Depends on wmts_pkg; sees only the top level's ports.

`default_nettype none

module wmts_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [wmts_pkg::M_TDATA_W-1:0]  m_tdata
);

    import wmts_pkg::*;

    // A stalled result beat keeps its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed or vanished while stalled");

    // Reset empties both queues.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("queues not empty after reset");

    // No result beat appears as reset is released.
    a_latency_floor: assert property (@(posedge aclk)
        !aresetn ##1 aresetn |=> !m_tvalid)
        else $error("result beat too soon after reset");

    // The pad bits above the window sum stay zero.
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:RES_W] == '0)
        else $error("pad bits of result beat not zero");

    // s_tready stays known while the sender is held off.
    a_in_ready_known: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> $past(s_tvalid) && !$isunknown(s_tready))
        else $error("input ready undefined under backpressure");

endmodule

bind window_mean_threshold_select wmts_checker u_wmts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ----- test/tb_window_mean_threshold_select.sv -----
// Self-checking testbench for window_mean_threshold_select: streams foreground samples,
// predicts every window hit in a scoreboard class and compares each result beat.
// Depends on wmts_pkg and the window_mean_threshold_select RTL.
`timescale 1ns / 1ps

module tb_window_mean_threshold_select;
    import wmts_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int SETTLE       = 20;
    localparam int RANDOM_ITEMS = 650;
    localparam int CALM_AFTER   = 500;
    localparam int MAX_SAMPLE   = 65535;

    // Layout of one result beat, lowest field last.
    typedef struct packed {
        logic [1:0]         pad;
        logic [SUM_W-1:0]   win_sum;
        logic [COORD_W-1:0] win_row;
        logic [COORD_W-1:0] win_col;
    } window_hit_t;

    class window_scoreboard;
        logic [IMG_DIM_W-1:0] image_width;
        logic [IMG_DIM_W-1:0] image_height;
        logic [WIN_DIM_W-1:0] win_width;
        logic [WIN_DIM_W-1:0] win_height;
        logic [THR_W-1:0]     threshold;
        logic [X_W-1:0]       line_mem [0:MAX_WIN_DEF*MAX_WIDTH_DEF-1];
        logic [COLSUM_W-1:0]  col_sum [0:MAX_WIDTH_DEF-1];
        logic [SUM_W-1:0]     win_acc;
        int                   col;
        int                   row;
        int                   narrowest;
        window_hit_t          hits_due[$];
        int                   fails;

        function new();
            image_width  = IMAGE_WIDTH_RST;
            image_height = IMAGE_HEIGHT_RST;
            win_width    = WIN_WIDTH_RST;
            win_height   = WIN_HEIGHT_RST;
            threshold    = THRESHOLD_RST;
            foreach (col_sum[i]) col_sum[i] = '0;
            win_acc   = '0;
            col       = 0;
            row       = 0;
            narrowest = MAX_WIDTH_DEF;
            fails     = 0;
        endfunction

        function int limit(input int v, input int lo, input int hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        function int eff_width();
            return limit(image_width, 1, MAX_WIDTH_DEF);
        endfunction

        function int eff_height();
            return limit(image_height, 1, ROWS_MAX);
        endfunction

        function void write_reg(input cfg_index_t idx, input int val);
            case (idx)
                REG_IMAGE_WIDTH:  image_width  = val[IMG_DIM_W-1:0];
                REG_IMAGE_HEIGHT: image_height = val[IMG_DIM_W-1:0];
                REG_WIN_WIDTH:    win_width    = val[WIN_DIM_W-1:0];
                REG_WIN_HEIGHT:   win_height   = val[WIN_DIM_W-1:0];
                REG_THRESHOLD:    threshold    = val[THR_W-1:0];
                default: ;
            endcase
        endfunction

        // Advances the raster position by one sample and queues the hit it causes, if any.
        function void note_sample(input logic [X_W-1:0] x, input logic first);
            int                  ew;
            int                  eh;
            int                  ww;
            int                  wh;
            int                  c;
            int                  r;
            logic [COLSUM_W-1:0] cs;
            longint              area;
            window_hit_t         hit;
            ew = eff_width();
            eh = eff_height();
            ww = limit(win_width, 1, MAX_WIN_DEF);
            wh = limit(win_height, 1, MAX_WIN_DEF);
            if (first) begin
                col = 0;
                row = 0;
            end
            c = col;
            r = row;
            // Track the narrowest row of this frame, which bounds safe mid-frame changes.
            if (c == 0 && r == 0) begin
                narrowest = ew;
            end else if (ew < narrowest) begin
                narrowest = ew;
            end
            if (r == 0) begin
                cs = COLSUM_W'(x);
            end else begin
                cs = col_sum[c] + x;
                if (r >= wh) begin
                    cs = cs - line_mem[((r - wh) % MAX_WIN_DEF) * MAX_WIDTH_DEF + c];
                end
            end
            col_sum[c] = cs;
            line_mem[(r % MAX_WIN_DEF) * MAX_WIDTH_DEF + c] = x;
            if (c == 0) begin
                win_acc = SUM_W'(cs);
            end else begin
                win_acc = win_acc + cs;
                if (c >= ww) begin
                    win_acc = win_acc - col_sum[c - ww];
                end
            end
            if (r + 1 >= wh && c + 1 >= ww) begin
                area = longint'(ww) * longint'(wh);
                if (longint'(win_acc) > longint'(threshold) * area) begin
                    hit.pad     = '0;
                    hit.win_col = COORD_W'(c + 1 - ww);
                    hit.win_row = COORD_W'(r + 1 - wh);
                    hit.win_sum = win_acc;
                    hits_due.push_back(hit);
                end
            end
            if (c + 1 >= ew) begin
                col = 0;
                row = (r + 1 >= eh) ? 0 : r + 1;
            end else begin
                col = c + 1;
                row = r;
            end
        endfunction

        function void flag(input string what, input longint want, input longint got);
            fails++;
            $display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
        endfunction

        function void check_result(input logic [M_TDATA_W-1:0] beat);
            window_hit_t got;
            window_hit_t want;
            got = beat;
            if (hits_due.size() == 0) begin
                fails++;
                $display("%0t: result beat expected none, actual %h", $time, beat);
                return;
            end
            want = hits_due.pop_front();
            if (got.win_col !== want.win_col) flag("win_col", want.win_col, got.win_col);
            if (got.win_row !== want.win_row) flag("win_row", want.win_row, got.win_row);
            if (got.win_sum !== want.win_sum) flag("win_sum", want.win_sum, got.win_sum);
            if (got.pad !== want.pad) flag("tdata padding", want.pad, got.pad);
        endfunction
    endclass

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  s_tvalid     = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata      = '0;
    logic                  s_tuser      = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready     = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data  = '0;

    window_scoreboard sb = new();
    bit               calm = 1'b0;
    int               rand_items = 0;
    int               rx_left = 0;

    window_mean_threshold_select u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // Receiver alternates ready runs with stall bursts until the calm tail of the run.
    // A stall burst is always followed by a ready run.
    always @(negedge aclk) begin
        if (calm) begin
            m_tready <= 1'b1;
        end else if (rx_left == 0) begin
            if (m_tready && $urandom_range(0, 3) == 0) begin
                rx_left = $urandom_range(0, 16);
                m_tready <= 1'b0;
            end else begin
                rx_left = $urandom_range(0, 40);
                m_tready <= 1'b1;
            end
        end else begin
            rx_left--;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata);
        end
    end

    task automatic feed_sample(input logic [X_W-1:0] x, input logic first);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        s_tuser  <= first;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_sample(x, first);
    endtask

    // Holds the sender until every predicted hit has come out, then lets the pipe settle.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.hits_due.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input int val);
        @(negedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= CFG_DATA_W'(val);
        @(posedge aclk);
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic feed_run(input int n, input logic restart, input bit saturate);
        for (int i = 0; i < n; i++) begin
            feed_sample(saturate ? X_W'(MAX_SAMPLE) : X_W'($urandom_range(0, MAX_SAMPLE)),
                        restart && i == 0);
        end
    endtask

    function automatic int pick_image_dim(input int usual_hi);
        case ($urandom_range(0, 19))
            0:       return 0;
            1:       return $urandom_range(MAX_WIDTH_DEF + 1, (1 << IMG_DIM_W) - 1);
            2:       return $urandom_range(usual_hi + 1, 64);
            default: return $urandom_range(1, usual_hi);
        endcase
    endfunction

    function automatic int pick_win_dim(input int span);
        case ($urandom_range(0, 19))
            0:       return 0;
            1:       return $urandom_range(MAX_WIN_DEF + 1, (1 << WIN_DIM_W) - 1);
            2:       return $urandom_range(1, MAX_WIN_DEF);
            default: return $urandom_range(1, span < 6 ? span : 6);
        endcase
    endfunction

    function automatic logic [X_W-1:0] pick_sample(input int mode, input int thr);
        int lo;
        int hi;
        lo = thr > 2000 ? thr - 2000 : 0;
        hi = thr < MAX_SAMPLE - 2000 ? thr + 2000 : MAX_SAMPLE;
        case (mode)
            1:       return X_W'($urandom_range(lo, hi));
            2:       return $urandom_range(0, 1) ? X_W'(MAX_SAMPLE) : '0;
            3:       return ($urandom_range(0, 3) == 0 && thr < MAX_SAMPLE) ? X_W'(thr + 1)
                                                                            : X_W'(thr);
            default: return X_W'($urandom_range(0, MAX_SAMPLE));
        endcase
    endfunction

    task automatic random_phase();
        int   mode;
        int   thr;
        int   frame;
        int   n;
        logic first;
        drain();
        if ($urandom_range(0, 1)) write_reg(REG_IMAGE_WIDTH, pick_image_dim(16));
        if ($urandom_range(0, 1)) write_reg(REG_IMAGE_HEIGHT, pick_image_dim(12));
        if ($urandom_range(0, 1)) write_reg(REG_WIN_WIDTH, pick_win_dim(sb.eff_width()));
        if ($urandom_range(0, 1)) write_reg(REG_WIN_HEIGHT, pick_win_dim(sb.eff_height()));
        mode = $urandom_range(0, 3);
        case (mode)
            0:       thr = $urandom_range(20000, 45000);
            2:       thr = ($urandom_range(0, 2) == 0) ? 0 :
                           ($urandom_range(0, 1) ? MAX_SAMPLE : $urandom_range(0, MAX_SAMPLE));
            default: thr = $urandom_range(0, MAX_SAMPLE);
        endcase
        write_reg(REG_THRESHOLD, thr);
        // A wider row than any row of the current frame would read unwritten line-store
        // entries, so such a phase must open a new frame.
        first = (sb.eff_width() > sb.narrowest) || ($urandom_range(0, 3) != 0);
        frame = sb.eff_width() * sb.eff_height();
        if (frame <= 150) begin
            n = frame * $urandom_range(1, 3) + $urandom_range(0, frame);
        end else begin
            n = $urandom_range(100, 300);
        end
        for (int i = 0; i < n; i++) begin
            feed_sample(pick_sample(mode, thr), first);
            first = ($urandom_range(0, 79) == 0);
            rand_items++;
            calm = (rand_items >= CALM_AFTER);
            if (!calm && $urandom_range(0, 63) == 0) drain();
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Tiny 3x2 image with a 2x2 window: two windows, both above one half.
        write_reg(REG_IMAGE_WIDTH, 3);
        write_reg(REG_IMAGE_HEIGHT, 2);
        write_reg(REG_WIN_WIDTH, 2);
        write_reg(REG_WIN_HEIGHT, 2);
        write_reg(REG_THRESHOLD, 16'h8000);
        feed_sample(16'hFFFF, 1'b1);
        feed_sample(16'h0000, 1'b0);
        feed_sample(16'h5555, 1'b0);
        feed_sample(16'hAAAA, 1'b0);
        feed_sample(16'hFFFF, 1'b0);
        feed_sample(16'hFFFF, 1'b0);

        // Single-sample windows: zero threshold, frame wrap and a restart mid-row,
        // then the strict test at equality.
        drain();
        write_reg(REG_IMAGE_HEIGHT, 1);
        write_reg(REG_WIN_WIDTH, 1);
        write_reg(REG_WIN_HEIGHT, 1);
        write_reg(REG_THRESHOLD, 0);
        feed_sample(16'h0000, 1'b1);
        feed_sample(16'h0001, 1'b0);
        feed_sample(16'hFFFF, 1'b0);
        feed_sample(16'h0002, 1'b0);
        feed_sample(16'hFFFF, 1'b1);
        drain();
        write_reg(REG_THRESHOLD, 16'h1234);
        feed_sample(16'h1234, 1'b0);
        feed_sample(16'h1235, 1'b0);

        // Window larger than the image never completes.
        drain();
        write_reg(REG_IMAGE_WIDTH, 2);
        write_reg(REG_IMAGE_HEIGHT, 2);
        write_reg(REG_WIN_WIDTH, 3);
        write_reg(REG_WIN_HEIGHT, 3);
        feed_run(4, 1'b1, 1'b1);

        // Out-of-range registers are clamped: a one-column image, 1024 rows, 1x1 window.
        drain();
        write_reg(REG_IMAGE_WIDTH, 0);
        write_reg(REG_IMAGE_HEIGHT, (1 << IMG_DIM_W) - 1);
        write_reg(REG_WIN_WIDTH, 0);
        write_reg(REG_WIN_HEIGHT, 0);
        write_reg(REG_THRESHOLD, 0);
        feed_sample(16'h0005, 1'b1);
        feed_sample(16'h0000, 1'b0);
        feed_sample(16'h0007, 1'b0);

        // Shrink the image in the middle of a frame; the current row ends at once.
        drain();
        write_reg(REG_IMAGE_WIDTH, 4);
        write_reg(REG_IMAGE_HEIGHT, 3);
        write_reg(REG_WIN_WIDTH, 2);
        write_reg(REG_WIN_HEIGHT, 2);
        feed_run(6, 1'b1, 1'b0);
        drain();
        write_reg(REG_IMAGE_WIDTH, 2);
        write_reg(REG_WIN_HEIGHT, 1);
        feed_run(4, 1'b0, 1'b0);

        // The largest window at saturation, with both window registers clamped.
        drain();
        write_reg(REG_IMAGE_WIDTH, MAX_WIN_DEF);
        write_reg(REG_IMAGE_HEIGHT, MAX_WIN_DEF);
        write_reg(REG_WIN_WIDTH, (1 << WIN_DIM_W) - 1);
        write_reg(REG_WIN_HEIGHT, (1 << WIN_DIM_W) - 1);
        write_reg(REG_THRESHOLD, MAX_SAMPLE - 1);
        feed_run(MAX_WIN_DEF * MAX_WIN_DEF, 1'b1, 1'b1);

        while (rand_items < RANDOM_ITEMS) random_phase();
        drain();

        if (sb.fails == 0) begin
            $display("window_mean_threshold_select: match");
        end else begin
            $display("window_mean_threshold_select: mismatch");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("window_mean_threshold_select: mismatch");
        $finish;
    end

endmodule
